/* rtl/motor_reply_frame_checker_defines.svh */
// ---------------------------------------------------------------------------
// motor reply frame checker assertion macros
// clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef MOTOR_REPLY_FRAME_CHECKER_DEFINES_SVH
`define MOTOR_REPLY_FRAME_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// implication that must hold at every rising clock edge outside reset
`define MRFC_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// implication checked in the cycle after the condition
`define MRFC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define MRFC_ASSERT_IMPLY(label, cond, prop, msg)
`define MRFC_ASSERT_NEXT(label, cond, prop, msg)

`endif

`endif

/* rtl/mrfc_pkg.sv */
// ---------------------------------------------------------------------------
// mrfc_pkg
// types, constants and crc function of the motor reply frame checker
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrfc_pkg;

    localparam int          CFG_INDEX_W      = 1;
    localparam int          CFG_DATA_W       = 8;
    localparam logic [7:0]  CRC_POLY         = 8'h8C;
    localparam logic [7:0]  RESET_REPLY_CODE = 8'h75;
    localparam logic [7:0]  STATUS_REPLY     = 8'h75;
    localparam logic [7:0]  SPEED_REPLY      = 8'h65;
    localparam int          PAYLOAD_FIRST    = 2;
    localparam int          PAYLOAD_LAST     = 7;
    localparam int          PAYLOAD_W        = 48;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEVICE_ADDRESS = 1'b0,
        CFG_REPLY_CODE     = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_HDR_ERR = 2'd2
    } frame_status_t;

    // reflected crc-8, one byte per call
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

/* rtl/motor_reply_frame_checker.sv */
// ---------------------------------------------------------------------------
// motor reply frame checker
// checks a fixed-length motor driver reply byte by byte and reports status
// ---------------------------------------------------------------------------
// usage:
//   byte channel (byte_valid, byte_stall, rx_byte) takes one reply byte per
//   item; byte FRAME_BYTES-1 of each frame is the crc check byte
//   reply channel (reply_valid, reply_stall) carries one item per frame:
//   frame_status plus the held mileage, position and speed values
//   a byte item can be taken in every cycle: crc update, header compare and
//   payload shift are one short combinational step into the frame registers
//   the reply item is valid the cycle after the last byte is taken
//   one byte per cycle unless the last byte is stalled, one reply per frame
//   only the last byte of a frame waits on the reply register; while a
//   finished reply is stalled, the bytes of the next frame still flow in
//   up to its last byte
//   the held values only move on a good frame, so they drive the reply
//   ports straight from their registers
//   reset clears the frame state and held values, sets the device address
//   to zero and the expected reply code to the status reply code
//   configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "motor_reply_frame_checker_defines.svh"

module motor_reply_frame_checker
    import mrfc_pkg::*;
#(
    parameter int FRAME_BYTES = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // byte channel
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  logic [7:0]             rx_byte,
    // reply channel
    output logic                   reply_valid,
    input  logic                   reply_stall,
    output logic [1:0]             frame_status,
    output logic signed [31:0]     mileage_count,
    output logic signed [15:0]     shaft_position,
    output logic signed [15:0]     speed_rpm
);

    localparam int             IDX_W    = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] PAY_LO   = IDX_W'(PAYLOAD_FIRST);
    localparam logic [IDX_W-1:0] PAY_HI   = IDX_W'(PAYLOAD_LAST);

    // configuration registers
    logic [7:0]            device_address_reg;
    logic [7:0]            reply_code_reg;

    // frame state
    logic [IDX_W-1:0]      byte_index_reg,  byte_index_next;
    logic [7:0]            running_crc_reg, running_crc_next;
    logic                  header_bad_reg,  header_bad_next;
    logic [PAYLOAD_W-1:0]  payload_reg,     payload_next;

    // held values and reply register
    logic [31:0]           held_mileage_reg,  held_mileage_next;
    logic [15:0]           held_position_reg, held_position_next;
    logic [15:0]           held_speed_reg,    held_speed_next;
    frame_status_t         status_reg,        status_next;
    logic                  reply_valid_reg,   reply_valid_next;

    logic                  is_last;
    logic                  byte_take;
    logic                  take_last;

    // the last byte needs a free reply register, others never wait
    assign is_last    = (byte_index_reg == LAST_IDX);
    assign byte_stall = is_last && reply_valid_reg && reply_stall;
    assign byte_take  = byte_valid && !byte_stall;
    assign take_last  = byte_take && is_last;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= '0;
            reply_code_reg     <= RESET_REPLY_CODE;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data;
                CFG_REPLY_CODE:     reply_code_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // per-byte frame step
    always_comb
    begin
        byte_index_next    = byte_index_reg;
        running_crc_next   = running_crc_reg;
        header_bad_next    = header_bad_reg;
        payload_next       = payload_reg;
        held_mileage_next  = held_mileage_reg;
        held_position_next = held_position_reg;
        held_speed_next    = held_speed_reg;
        status_next        = status_reg;
        reply_valid_next   = reply_valid_reg && reply_stall;

        if (byte_take)
        begin
            if (!is_last)
            begin
                running_crc_next = crc8_update(running_crc_reg, rx_byte);
                // address in byte 0, reply code in byte 1
                if (byte_index_reg == '0 && rx_byte != device_address_reg)
                    header_bad_next = 1'b1;
                if (byte_index_reg == IDX_W'(1) && rx_byte != reply_code_reg)
                    header_bad_next = 1'b1;
                if (byte_index_reg inside {[PAY_LO:PAY_HI]})
                    payload_next = {payload_reg[PAYLOAD_W-9:0], rx_byte};
                byte_index_next = byte_index_reg + IDX_W'(1);
            end
            else
            begin
                // crc fault wins over a header fault
                if (running_crc_reg != rx_byte)
                    status_next = ST_CRC_ERR;
                else if (header_bad_reg)
                    status_next = ST_HDR_ERR;
                else
                begin
                    status_next        = ST_OK;
                    held_mileage_next  = payload_reg[47:16];
                    held_position_next = payload_reg[15:0];
                    held_speed_next    = payload_reg[47:32];
                end
                reply_valid_next = 1'b1;
                byte_index_next  = '0;
                running_crc_next = '0;
                header_bad_next  = 1'b0;
                payload_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg    <= '0;
            running_crc_reg   <= '0;
            header_bad_reg    <= 1'b0;
            payload_reg       <= '0;
            held_mileage_reg  <= '0;
            held_position_reg <= '0;
            held_speed_reg    <= '0;
            status_reg        <= ST_OK;
            reply_valid_reg   <= 1'b0;
        end
        else
        begin
            byte_index_reg    <= byte_index_next;
            running_crc_reg   <= running_crc_next;
            header_bad_reg    <= header_bad_next;
            payload_reg       <= payload_next;
            held_mileage_reg  <= held_mileage_next;
            held_position_reg <= held_position_next;
            held_speed_reg    <= held_speed_next;
            status_reg        <= status_next;
            reply_valid_reg   <= reply_valid_next;
        end
    end

    assign reply_valid    = reply_valid_reg;
    assign frame_status   = status_reg;
    assign mileage_count  = held_mileage_reg;
    assign shaft_position = held_position_reg;
    assign speed_rpm      = held_speed_reg;

    `MRFC_ASSERT_IMPLY(a_index_in_frame, 1'b1, byte_index_reg <= LAST_IDX,
        "byte index ran past the check byte")
    `MRFC_ASSERT_NEXT(a_frame_restart, take_last,
        byte_index_reg == '0 && running_crc_reg == '0 && !header_bad_reg && payload_reg == '0,
        "frame state not cleared after the check byte")
    `MRFC_ASSERT_IMPLY(a_reply_from_last, $rose(reply_valid_reg), $past(take_last),
        "reply raised without a check byte")
    `MRFC_ASSERT_IMPLY(a_held_only_on_good, !$stable(held_mileage_reg),
        reply_valid_reg && status_reg == ST_OK,
        "held mileage moved without a good frame")

endmodule

/* sim/tb_motor_reply_frame_checker.sv */
// ---------------------------------------------------------------------------
// motor reply frame checker testbench
// sends reply frames byte by byte under several handshake patterns and checks
// every reply item against a predictor of crc, header and held-value logic
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_motor_reply_frame_checker;
    import mrfc_pkg::*;

    localparam int FRAME_BYTES    = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int FRAMES_PER_RUN = 28;
    localparam int SHOWN_ERRORS   = 10;

    // kinds of frame the stimulus builds
    typedef enum
    {
        FK_GOOD,
        FK_BAD_CRC,
        FK_BAD_ADDR,
        FK_BAD_CODE,
        FK_BOTH,
        FK_NOISE
    } frame_kind_t;

    // one reply item as the block should show it
    typedef struct
    {
        frame_status_t      status;
        logic signed [31:0] mileage;
        logic signed [15:0] position;
        logic signed [15:0] speed;
    } reply_t;

    // reflected crc-8 step, lsb first
    function automatic logic [7:0] maxim_crc_step(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] x;
        x = acc ^ d;
        repeat (8)
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        return x;
    endfunction

    // -----------------------------------------------------------------------
    // frame predictor and reply scoreboard
    // -----------------------------------------------------------------------
    class frame_check_scoreboard;
        logic [7:0]  addr_reg;
        logic [7:0]  code_reg;
        int          byte_pos;
        logic [7:0]  crc_acc;
        bit          hdr_bad;
        logic [47:0] payload;
        logic [31:0] held_mileage;
        logic [15:0] held_position;
        logic [15:0] held_speed;
        reply_t      pending_replies[$];
        int          errors;
        int          bytes_seen;
        int          replies_seen;
        int          good_frames;
        int          crc_frames;
        int          hdr_frames;

        function new();
            addr_reg      = 8'h00;
            code_reg      = RESET_REPLY_CODE;
            byte_pos      = 0;
            crc_acc       = 8'h00;
            hdr_bad       = 1'b0;
            payload       = '0;
            held_mileage  = '0;
            held_position = '0;
            held_speed    = '0;
            errors        = 0;
            bytes_seen    = 0;
            replies_seen  = 0;
            good_frames   = 0;
            crc_frames    = 0;
            hdr_frames    = 0;
        endfunction

        function void note_config(cfg_index_t idx, logic [7:0] val);
            if (idx == CFG_DEVICE_ADDRESS)
                addr_reg = val;
            else
                code_reg = val;
        endfunction

        // accepted byte: advance the frame, queue a reply on the check byte
        function void take_byte(logic [7:0] b);
            reply_t r;
            bytes_seen++;
            if (byte_pos + 1 < FRAME_BYTES)
            begin
                crc_acc = maxim_crc_step(crc_acc, b);
                if (byte_pos == 0 && b != addr_reg)
                    hdr_bad = 1'b1;
                if (byte_pos == 1 && b != code_reg)
                    hdr_bad = 1'b1;
                if (byte_pos >= PAYLOAD_FIRST && byte_pos <= PAYLOAD_LAST)
                    payload = {payload[39:0], b};
                byte_pos++;
                return;
            end
            if (crc_acc != b)
            begin
                r.status = ST_CRC_ERR;
                crc_frames++;
            end
            else if (hdr_bad)
            begin
                r.status = ST_HDR_ERR;
                hdr_frames++;
            end
            else
            begin
                r.status      = ST_OK;
                held_mileage  = payload[47:16];
                held_position = payload[15:0];
                held_speed    = payload[47:32];
                good_frames++;
            end
            r.mileage  = held_mileage;
            r.position = held_position;
            r.speed    = held_speed;
            pending_replies.push_back(r);
            byte_pos = 0;
            crc_acc  = 8'h00;
            hdr_bad  = 1'b0;
            payload  = '0;
        endfunction

        function void flag(string what, logic [31:0] exp_val, logic [31:0] got_val);
            errors++;
            if (errors <= SHOWN_ERRORS)
                $display("%0t: %s: expected %h, got %h", $realtime, what, exp_val, got_val);
        endfunction

        // accepted reply: compare with the oldest queued reply
        function void check_reply(logic [1:0] st, logic [31:0] m, logic [15:0] p,
                                  logic [15:0] s);
            reply_t e;
            replies_seen++;
            if (pending_replies.size() == 0)
            begin
                flag("reply with no frame pending, status", '0, st);
                return;
            end
            e = pending_replies.pop_front();
            if (st !== e.status)
                flag("frame_status", e.status, st);
            if (m !== e.mileage)
                flag("mileage_count", e.mileage, m);
            if (p !== e.position)
                flag("shaft_position", e.position, p);
            if (s !== e.speed)
                flag("speed_rpm", e.speed, s);
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // signals and block
    // -----------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   byte_valid;
    logic                   byte_stall;
    logic [7:0]             rx_byte;
    logic                   reply_valid;
    logic                   reply_stall;
    logic [1:0]             frame_status;
    logic signed [31:0]     mileage_count;
    logic signed [15:0]     shaft_position;
    logic signed [15:0]     speed_rpm;

    frame_check_scoreboard sb = new();

    // idle percentages of sender and receiver, set per phase
    int sender_idle_pct;
    int receiver_stall_pct;
    int quiet_cycles;

    // register values the frame builder aims at
    logic [7:0] dev_addr;
    logic [7:0] reply_code;

    motor_reply_frame_checker #(
        .FRAME_BYTES(FRAME_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .rx_byte(rx_byte),
        .reply_valid(reply_valid),
        .reply_stall(reply_stall),
        .frame_status(frame_status),
        .mileage_count(mileage_count),
        .shaft_position(shaft_position),
        .speed_rpm(speed_rpm)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // receiver side: random stall, changed at the falling edge only
    always @(negedge clk)
        reply_stall <= ($urandom_range(99) < receiver_stall_pct);

    // -----------------------------------------------------------------------
    // monitor: everything is sampled at the rising edge, before the block's
    // registers move; replies are checked before the byte of the same edge
    // is noted, since a reply always belongs to an earlier frame
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (reply_valid && !reply_stall)
                sb.check_reply(frame_status, mileage_count, shaft_position, speed_rpm);
            if (byte_valid && !byte_stall)
                sb.take_byte(rx_byte);
            if (cfg_we)
                sb.note_config(cfg_index_t'(cfg_index), cfg_data);
            if ((reply_valid && !reply_stall) || (byte_valid && !byte_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // drivers
    // -----------------------------------------------------------------------

    // offer one byte, with random idle cycles before it; returns at the
    // edge that takes it, valid stays high so back-to-back items flow
    task automatic put_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        rx_byte    <= b;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
    endtask

    // drop valid and let every queued reply drain
    task automatic settle();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (3)
            @(negedge clk);
    endtask

    // one-cycle register write, byte channel idle
    task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_DEVICE_ADDRESS)
            dev_addr = val;
        else
            reply_code = val;
    endtask

    // six payload bytes, often at the signed extremes
    function automatic logic [47:0] rand_payload();
        logic [47:0] pl;
        logic [7:0]  corners[4];
        corners = '{8'h00, 8'hFF, 8'h7F, 8'h80};
        for (int i = 0; i < 6; i++)
            pl = {pl[39:0], ($urandom_range(3) == 0) ? corners[$urandom_range(3)]
                                                     : 8'($urandom)};
        return pl;
    endfunction

    // build and send one whole frame; with pause_mid set, both registers
    // are rewritten after the address byte so the code byte meets new values
    task automatic send_frame(input frame_kind_t kind, input logic [47:0] pl,
                              input bit pause_mid);
        logic [7:0] fb[FRAME_BYTES];
        logic [7:0] crc;
        fb[0] = dev_addr;
        if (kind == FK_BAD_ADDR || kind == FK_BOTH)
            fb[0] ^= 8'($urandom_range(1, 255));
        if (kind == FK_NOISE)
            fb[0] = 8'($urandom);
        put_byte(fb[0]);
        if (pause_mid)
        begin
            settle();
            write_reg(CFG_DEVICE_ADDRESS, 8'hA5);
            write_reg(CFG_REPLY_CODE, SPEED_REPLY);
        end
        fb[1] = reply_code;
        if (kind == FK_BAD_CODE)
            fb[1] ^= 8'($urandom_range(1, 255));
        for (int i = 2; i < FRAME_BYTES - 1; i++)
        begin
            if (i <= PAYLOAD_LAST)
                fb[i] = pl[8 * (PAYLOAD_LAST - i) +: 8];
            else
                fb[i] = 8'($urandom);
        end
        crc = 8'h00;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            crc = maxim_crc_step(crc, fb[i]);
        fb[FRAME_BYTES - 1] = crc;
        if (kind == FK_BAD_CRC || kind == FK_BOTH)
            fb[FRAME_BYTES - 1] ^= 8'($urandom_range(1, 255));
        if (kind == FK_NOISE)
            for (int i = 1; i < FRAME_BYTES; i++)
                fb[i] = 8'($urandom);
        for (int i = 1; i < FRAME_BYTES; i++)
            put_byte(fb[i]);
    endtask

    // -----------------------------------------------------------------------
    // stimulus
    // -----------------------------------------------------------------------
    initial
    begin
        int          pick;
        frame_kind_t kind;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_DEVICE_ADDRESS;
        cfg_data           = '0;
        byte_valid         = 1'b0;
        rx_byte            = 8'h00;
        reply_stall        = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        quiet_cycles       = 0;
        dev_addr           = 8'h00;
        reply_code         = RESET_REPLY_CODE;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: good frame at reset values with the most negative payload
        send_frame(FK_GOOD, 48'h8000_0000_8000, 1'b0);
        // address and crc both wrong: crc wins, held values stay
        send_frame(FK_BOTH, 48'hFFFF_FFFF_FFFF, 1'b0);
        // registers rewritten mid-frame, most positive payload
        send_frame(FK_GOOD, 48'h7FFF_FFFF_7FFF, 1'b1);

        // random phases, each with its own register setting and idle pattern
        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    write_reg(CFG_DEVICE_ADDRESS, 8'hFF);
                    write_reg(CFG_REPLY_CODE, SPEED_REPLY);
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    write_reg(CFG_DEVICE_ADDRESS, 8'h00);
                    write_reg(CFG_REPLY_CODE, 8'h00);
                    sender_idle_pct    = 87;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    write_reg(CFG_DEVICE_ADDRESS, 8'($urandom));
                    write_reg(CFG_REPLY_CODE, 8'hFF);
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 87;
                end
                default:
                begin
                    write_reg(CFG_DEVICE_ADDRESS, 8'($urandom));
                    write_reg(CFG_REPLY_CODE, STATUS_REPLY);
                    sender_idle_pct    = 21;
                    receiver_stall_pct = 21;
                end
            endcase
            // mostly good frames with random content, the rest faulty or noise
            for (int f = 0; f < FRAMES_PER_RUN; f++)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    kind = FK_GOOD;
                else if (pick < 70)
                    kind = FK_BAD_CRC;
                else if (pick < 78)
                    kind = FK_BAD_ADDR;
                else if (pick < 86)
                    kind = FK_BAD_CODE;
                else if (pick < 92)
                    kind = FK_BOTH;
                else
                    kind = FK_NOISE;
                send_frame(kind, rand_payload(), 1'b0);
            end
        end

        // drain, then check that no queued reply is left
        settle();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (5)
            @(posedge clk);
        if (sb.pending_replies.size() != 0)
        begin
            $display("%0d replies never arrived", sb.pending_replies.size());
            sb.errors += sb.pending_replies.size();
        end

        $display("run covered %0d bytes and %0d replies: %0d good, %0d crc, %0d header",
                 sb.bytes_seen, sb.replies_seen, sb.good_frames, sb.crc_frames,
                 sb.hdr_frames);
        $display("four handshake patterns, mid-frame register writes, %0d mismatches",
                 sb.errors);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
